/* design/ordered_key_value_table_unit_defines.svh */
// assertion macros shared by the key/value table design
`ifndef ORDERED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define OKVT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OKVT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/okvt_pkg.sv */
// shared types, codes and defaults of the key/value table
`timescale 1ns / 1ps

package okvt_pkg;

  // default geometry
  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // fixed port field widths
  localparam int OP_W     = 3;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP   = 3'd0,
    OP_REGISTER = 3'd1,
    OP_ERASE    = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_READ     = 3'd4
  } okvt_op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } okvt_status_e;

  // one result as seen on the output ports
  typedef struct packed {
    okvt_status_e     status;
    logic             newly_added;
    logic [KEY_W-1:0] found_key;
    logic [VAL_W-1:0] found_value;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] entry_count;
  } okvt_result_t;

endpackage

/* design/okvt_ram.sv */
// simple dual-port synchronous memory with registered read data
`timescale 1ns / 1ps

module okvt_ram #(
  parameter int WIDTH = okvt_pkg::KEY_BITS_DEF,
  parameter int DEPTH = okvt_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/okvt_ctrl.sv */
// request sequencer: linear scan, append, erase compaction, clear and indexed read
`timescale 1ns / 1ps

module okvt_ctrl #(
  parameter int DEPTH      = okvt_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [okvt_pkg::OP_W-1:0]     operation_i,
  input  logic [okvt_pkg::KEY_W-1:0]    key_i,
  input  logic [okvt_pkg::VAL_W-1:0]    value_i,
  input  logic                          update_existing_i,
  input  logic [okvt_pkg::IDX_W-1:0]    index_i,
  // result handoff
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output okvt_pkg::okvt_result_t        res_o,
  // memory ports
  output logic [$clog2(DEPTH)-1:0]      raddr_o,
  input  logic [KEY_BITS-1:0]           rd_key_i,
  input  logic [VALUE_BITS-1:0]         rd_val_i,
  output logic [$clog2(DEPTH)-1:0]      waddr_o,
  output logic                          key_we_o,
  output logic                          val_we_o,
  output logic [KEY_BITS-1:0]           wkey_o,
  output logic [VALUE_BITS-1:0]         wval_o
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_MISS   = 6'b001000,
    S_RDWAIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        ptr_q, ptr_d;
  logic [okvt_pkg::OP_W-1:0] op_q, op_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic                   upd_q, upd_d;
  okvt_pkg::okvt_result_t res_q, res_d;

  logic [KEY_BITS+31:0]   kin_x, rdk_x, keyq_x;
  logic [VALUE_BITS+31:0] vin_x, rdv_x, valq_x;
  logic [CntW+3:0]        idx_x, cnt_x, ptr_x;
  logic [CntW+4:0]        cnt5_x;
  logic [CntW-1:0]        ptr_p1, ptr_p2;
  logic                   accept, idx_ok, hit, last;

  // field widening and masking to the configured widths
  assign kin_x  = {{KEY_BITS{1'b0}}, key_i};
  assign vin_x  = {{VALUE_BITS{1'b0}}, value_i};
  assign rdk_x  = {32'b0, rd_key_i};
  assign keyq_x = {32'b0, key_q};
  assign rdv_x  = {32'b0, rd_val_i};
  assign valq_x = {32'b0, val_q};
  assign idx_x  = {{CntW{1'b0}}, index_i};
  assign cnt_x  = {4'b0, cnt_q};
  assign ptr_x  = {4'b0, ptr_q};
  assign cnt5_x = {5'b0, cnt_q};

  // scan pointer arithmetic and compares
  assign ptr_p1 = ptr_q + CntW'(1);
  assign ptr_p2 = ptr_q + CntW'(2);
  assign idx_ok = idx_x < cnt_x;
  assign hit    = rd_key_i == key_q;
  assign last   = ptr_p1 == cnt_q;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;

  // result with the current entry count
  always_comb begin
    res_o             = res_q;
    res_o.entry_count = cnt5_x[okvt_pkg::CNT_W-1:0];
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    op_d     = op_q;
    key_d    = key_q;
    val_d    = val_q;
    upd_d    = upd_q;
    res_d    = res_q;
    raddr_o  = '0;
    waddr_o  = ptr_q[IdxW-1:0];
    key_we_o = 1'b0;
    val_we_o = 1'b0;
    wkey_o   = key_q;
    wval_o   = val_q;

    case (state_q)
      S_IDLE: begin
        if (operation_i == okvt_pkg::OP_READ) begin
          raddr_o = idx_x[IdxW-1:0];
        end
        if (accept) begin
          op_d  = operation_i;
          key_d = kin_x[KEY_BITS-1:0];
          val_d = vin_x[VALUE_BITS-1:0];
          upd_d = update_existing_i;
          ptr_d = '0;
          res_d = '0;
          case (operation_i)
            okvt_pkg::OP_LOOKUP, okvt_pkg::OP_REGISTER, okvt_pkg::OP_ERASE: begin
              state_d = (cnt_q == '0) ? S_MISS : S_SCAN;
            end
            okvt_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = S_DONE;
            end
            okvt_pkg::OP_READ: begin
              if (idx_ok) begin
                ptr_d   = idx_x[CntW-1:0];
                state_d = S_RDWAIT;
              end else begin
                res_d.status = okvt_pkg::ST_RANGE;
                state_d      = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // compare one entry per cycle, next read already in flight
      S_SCAN: begin
        raddr_o = ptr_p1[IdxW-1:0];
        if (hit) begin
          res_d.found_key   = rdk_x[okvt_pkg::KEY_W-1:0];
          res_d.found_value = rdv_x[okvt_pkg::VAL_W-1:0];
          res_d.position    = ptr_x[okvt_pkg::IDX_W-1:0];
          case (op_q)
            okvt_pkg::OP_REGISTER: begin
              if (upd_q) begin
                val_we_o          = 1'b1;
                res_d.found_value = valq_x[okvt_pkg::VAL_W-1:0];
              end
              state_d = S_DONE;
            end
            okvt_pkg::OP_ERASE: begin
              state_d = S_SHIFT;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else if (last) begin
          state_d = S_MISS;
        end else begin
          ptr_d = ptr_p1;
        end
      end

      // move the entry above the pointer down by one place
      S_SHIFT: begin
        raddr_o = ptr_p2[IdxW-1:0];
        if (ptr_p1 < cnt_q) begin
          key_we_o = 1'b1;
          val_we_o = 1'b1;
          wkey_o   = rd_key_i;
          wval_o   = rd_val_i;
          ptr_d    = ptr_p1;
        end else begin
          cnt_d   = cnt_q - CntW'(1);
          state_d = S_DONE;
        end
      end

      // key absent: append on register unless full, else report a miss
      S_MISS: begin
        if (op_q == okvt_pkg::OP_REGISTER) begin
          if (cnt_q == CntW'(DEPTH)) begin
            res_d.status = okvt_pkg::ST_FULL;
          end else begin
            waddr_o           = cnt_q[IdxW-1:0];
            key_we_o          = 1'b1;
            val_we_o          = 1'b1;
            res_d.found_key   = keyq_x[okvt_pkg::KEY_W-1:0];
            res_d.found_value = valq_x[okvt_pkg::VAL_W-1:0];
            res_d.position    = cnt_x[okvt_pkg::IDX_W-1:0];
            res_d.newly_added = 1'b1;
            cnt_d             = cnt_q + CntW'(1);
          end
        end else begin
          res_d.status = okvt_pkg::ST_MISS;
        end
        state_d = S_DONE;
      end

      // indexed entry arrives from memory
      S_RDWAIT: begin
        res_d.found_key   = rdk_x[okvt_pkg::KEY_W-1:0];
        res_d.found_value = rdv_x[okvt_pkg::VAL_W-1:0];
        res_d.position    = ptr_x[okvt_pkg::IDX_W-1:0];
        state_d           = S_DONE;
      end

      // hand the result to the output register
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    op_q  <= op_d;
    key_q <= key_d;
    val_q <= val_d;
    upd_q <= upd_d;
    res_q <= res_d;
  end

endmodule

/* design/okvt_out.sv */
// output register between the sequencer and the result channel
`timescale 1ns / 1ps

module okvt_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  output logic                   res_ready_o,
  input  okvt_pkg::okvt_result_t res_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output okvt_pkg::okvt_result_t res_o
);

  logic                   valid_q, valid_d;
  logic                   load;
  okvt_pkg::okvt_result_t data_q;

  // slot is free when empty or drained this cycle
  assign res_ready_o = !valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;
  assign valid_d     = load || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign res_o       = data_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // held result
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

endmodule

/* design/ordered_key_value_table_unit.sv */
// Ordered key/value table: a linear scan of the key memory sets the latency.
// Lookup, register and erase compare the stored keys in order until one
// matches; an absent key is appended on register while there is room, else
// reported, and erase moves each later entry down by one place. Read fetches
// the indexed entry. One request is in work at a time; the next is taken once
// the result is registered. Reset clears the count and handshake, not memories.
`timescale 1ns / 1ps
`include "ordered_key_value_table_unit_defines.svh"

module ordered_key_value_table_unit #(
  parameter int DEPTH      = okvt_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = okvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = okvt_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [okvt_pkg::OP_W-1:0]        operation_i,
  input  logic [okvt_pkg::KEY_W-1:0]       key_i,
  input  logic [okvt_pkg::VAL_W-1:0]       value_i,
  input  logic                             update_existing_i,
  input  logic [okvt_pkg::IDX_W-1:0]       index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [okvt_pkg::STATUS_W-1:0]    status_o,
  output logic                             newly_added_o,
  output logic [okvt_pkg::KEY_W-1:0]       found_key_o,
  output logic [okvt_pkg::VAL_W-1:0]       found_value_o,
  output logic [okvt_pkg::IDX_W-1:0]       position_o,
  output logic [okvt_pkg::CNT_W-1:0]       entry_count_o
);

  localparam int IdxW = $clog2(DEPTH);

  logic                   res_valid, res_ready;
  okvt_pkg::okvt_result_t ctrl_res, out_res;
  logic [IdxW-1:0]        raddr, waddr;
  logic [KEY_BITS-1:0]    rd_key, wkey;
  logic [VALUE_BITS-1:0]  rd_val, wval;
  logic                   key_we, val_we;

  // sequencer
  okvt_ctrl #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .key_i             (key_i),
    .value_i           (value_i),
    .update_existing_i (update_existing_i),
    .index_i           (index_i),
    .res_valid_o       (res_valid),
    .res_ready_i       (res_ready),
    .res_o             (ctrl_res),
    .raddr_o           (raddr),
    .rd_key_i          (rd_key),
    .rd_val_i          (rd_val),
    .waddr_o           (waddr),
    .key_we_o          (key_we),
    .val_we_o          (val_we),
    .wkey_o            (wkey),
    .wval_o            (wval)
  );

  // key memory
  okvt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (wkey),
    .raddr_i (raddr),
    .rdata_o (rd_key)
  );

  // value memory
  okvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (waddr),
    .wdata_i (wval),
    .raddr_i (raddr),
    .rdata_o (rd_val)
  );

  // result register
  okvt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (ctrl_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  // result fields onto the ports
  assign status_o      = out_res.status;
  assign newly_added_o = out_res.newly_added;
  assign found_key_o   = out_res.found_key;
  assign found_value_o = out_res.found_value;
  assign position_o    = out_res.position;
  assign entry_count_o = out_res.entry_count;

  // checks
  `OKVT_ASSERT_NOW(a_stall_while_result, res_valid, in_stall_o, "request taken with result pending")
  `OKVT_ASSERT_NEXT(a_handoff_shows, res_valid && res_ready, out_valid_o, "result handoff lost")
  `OKVT_ASSERT_NOW(a_no_accept_at_handoff, in_valid_i && !in_stall_o, !res_valid, "accept during handoff")
  `OKVT_ASSERT_NOW(a_added_is_ok, out_valid_o && newly_added_o, status_o == okvt_pkg::ST_OK, "added entry with error status")

endmodule

/* bench/testbench.sv */
// self-checking testbench of the ordered key/value table unit
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH = okvt_pkg::DEPTH_DEF;
  localparam int CLK_HALF = 6;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_REPORTS = 10;
  localparam int POOL_MAX = 32;
  // operation codes the block treats as no-ops
  localparam logic [okvt_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [okvt_pkg::OP_W-1:0] OP_UNUSED_LAST = 3'd7;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [okvt_pkg::OP_W-1:0]     operation_i;
  logic [okvt_pkg::KEY_W-1:0]    key_i;
  logic [okvt_pkg::VAL_W-1:0]    value_i;
  logic                          update_existing_i;
  logic [okvt_pkg::IDX_W-1:0]    index_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [okvt_pkg::STATUS_W-1:0] status_o;
  logic                          newly_added_o;
  logic [okvt_pkg::KEY_W-1:0]    found_key_o;
  logic [okvt_pkg::VAL_W-1:0]    found_value_o;
  logic [okvt_pkg::IDX_W-1:0]    position_o;
  logic [okvt_pkg::CNT_W-1:0]    entry_count_o;

  // shadow copy of the table contents
  logic [okvt_pkg::KEY_W-1:0] table_keys [TABLE_DEPTH];
  logic [okvt_pkg::VAL_W-1:0] table_vals [TABLE_DEPTH];
  int                         table_fill;

  okvt_pkg::okvt_result_t     awaited_results [$];
  logic [okvt_pkg::KEY_W-1:0] key_pool [POOL_MAX];
  int                         mismatch_count;
  int                         results_checked;
  int                         op_tally [8];
  int                         full_seen;
  int                         peak_fill;
  bit                         no_idle;

  ordered_key_value_table_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .key_i            (key_i),
    .value_i          (value_i),
    .update_existing_i(update_existing_i),
    .index_i          (index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .newly_added_o    (newly_added_o),
    .found_key_o      (found_key_o),
    .found_value_o    (found_value_o),
    .position_o       (position_o),
    .entry_count_o    (entry_count_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    #8_400_000;
    $display("TB_ERROR");
    $finish;
  end

  // apply one request to the shadow table and return the result it should give
  function automatic okvt_pkg::okvt_result_t table_outcome(
      logic [okvt_pkg::OP_W-1:0] op, logic [okvt_pkg::KEY_W-1:0] key,
      logic [okvt_pkg::VAL_W-1:0] val, logic upd, logic [okvt_pkg::IDX_W-1:0] idx);
    okvt_pkg::okvt_result_t r;
    int hit;
    r = '0;
    r.status = okvt_pkg::ST_OK;
    hit = TABLE_DEPTH;
    for (int i = 0; i < table_fill; i++) begin
      if (hit == TABLE_DEPTH && table_keys[i] == key) hit = i;
    end
    case (op)
      okvt_pkg::OP_LOOKUP: begin
        if (hit < TABLE_DEPTH) begin
          r.found_key = table_keys[hit];
          r.found_value = table_vals[hit];
          r.position = 4'(hit);
        end else begin
          r.status = okvt_pkg::ST_MISS;
        end
      end
      okvt_pkg::OP_REGISTER: begin
        if (hit < TABLE_DEPTH) begin
          if (upd) table_vals[hit] = val;
          r.found_key = table_keys[hit];
          r.found_value = table_vals[hit];
          r.position = 4'(hit);
        end else if (table_fill >= TABLE_DEPTH) begin
          r.status = okvt_pkg::ST_FULL;
        end else begin
          table_keys[table_fill] = key;
          table_vals[table_fill] = val;
          r.found_key = key;
          r.found_value = val;
          r.position = 4'(table_fill);
          r.newly_added = 1'b1;
          table_fill++;
        end
      end
      okvt_pkg::OP_ERASE: begin
        if (hit < TABLE_DEPTH) begin
          r.found_key = table_keys[hit];
          r.found_value = table_vals[hit];
          r.position = 4'(hit);
          // close the gap, keeping insertion order
          for (int i = hit; i + 1 < table_fill; i++) begin
            table_keys[i] = table_keys[i + 1];
            table_vals[i] = table_vals[i + 1];
          end
          table_fill--;
        end else begin
          r.status = okvt_pkg::ST_MISS;
        end
      end
      okvt_pkg::OP_CLEAR: table_fill = 0;
      okvt_pkg::OP_READ: begin
        if (idx < table_fill) begin
          r.found_key = table_keys[idx];
          r.found_value = table_vals[idx];
          r.position = idx;
        end else begin
          r.status = okvt_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
    r.entry_count = 5'(table_fill);
    return r;
  endfunction

  // compare one result field, report the first few differences
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // result checking, then prediction of any request taken at this edge
  always @(posedge clk_i) begin
    okvt_pkg::okvt_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result with no request outstanding, status %0d count %0d",
                     $time, status_o, entry_count_o);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("newly_added", 32'(want.newly_added), 32'(newly_added_o));
          check_field("found_key", want.found_key, found_key_o);
          check_field("found_value", want.found_value, found_value_o);
          check_field("position", 32'(want.position), 32'(position_o));
          check_field("entry_count", 32'(want.entry_count), 32'(entry_count_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = table_outcome(operation_i, key_i, value_i, update_existing_i, index_i);
        awaited_results.push_back(want);
        op_tally[operation_i]++;
        if (want.status == okvt_pkg::ST_FULL) full_seen++;
        if (table_fill > peak_fill) peak_fill = table_fill;
      end
    end
  end

  // random run length for idle and stall stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output back-pressure
  initial begin
    int run;
    int r;
    out_stall_i = 1'b0;
    run = 0;
    forever begin
      @(negedge clk_i);
      if (no_idle) begin
        out_stall_i <= 1'b0;
        run = 0;
      end else if (run == 0) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(1, 8);
        end else if (r < 75) begin
          out_stall_i <= 1'b1;
          run = $urandom_range(1, 3);
        end else if (r < 92) begin
          out_stall_i <= 1'b0;
          run = $urandom_range(20, 80);
        end else begin
          out_stall_i <= 1'b1;
          run = $urandom_range(15, 50);
        end
      end else begin
        run--;
      end
    end
  end

  // present one request, optionally after an idle gap, and wait until taken
  task automatic send_request(logic [okvt_pkg::OP_W-1:0] op, logic [okvt_pkg::KEY_W-1:0] key,
                              logic [okvt_pkg::VAL_W-1:0] val, logic upd,
                              logic [okvt_pkg::IDX_W-1:0] idx);
    int gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    key_i <= key;
    value_i <= val;
    update_existing_i <= upd;
    index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // new set of keys for a traffic phase; extremes included
  task automatic refresh_pool(int pool_size);
    for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
  endtask

  // weighted random traffic over a small key set so entries get hit
  task automatic run_traffic(int count, int pool_size, int w_reg, int w_look, int w_erase,
                             int w_read, int w_clear, int w_odd);
    int r;
    logic [okvt_pkg::OP_W-1:0] op;
    logic [okvt_pkg::KEY_W-1:0] key;
    logic [okvt_pkg::IDX_W-1:0] idx;
    refresh_pool(pool_size);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, w_reg + w_look + w_erase + w_read + w_clear + w_odd - 1);
      if (r < w_reg) op = okvt_pkg::OP_REGISTER;
      else if (r < w_reg + w_look) op = okvt_pkg::OP_LOOKUP;
      else if (r < w_reg + w_look + w_erase) op = okvt_pkg::OP_ERASE;
      else if (r < w_reg + w_look + w_erase + w_read) op = okvt_pkg::OP_READ;
      else if (r < w_reg + w_look + w_erase + w_read + w_clear) op = okvt_pkg::OP_CLEAR;
      else op = okvt_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, pool_size - 1)];
      else key = $urandom();
      if ($urandom_range(0, 99) < 60 && table_fill > 0) idx = 4'($urandom_range(0, table_fill - 1));
      else idx = 4'($urandom_range(0, TABLE_DEPTH - 1));
      send_request(op, key, $urandom(), 1'($urandom_range(0, 1)), idx);
    end
  endtask

  // lookup, erase, read, clear and an unused code against an empty table
  task automatic test_empty_table();
    send_request(okvt_pkg::OP_LOOKUP, 32'h1234_5678, '0, 1'b0, '0);
    send_request(okvt_pkg::OP_ERASE, 32'h1234_5678, '0, 1'b0, '0);
    send_request(okvt_pkg::OP_READ, '0, '0, 1'b0, '0);
    send_request(okvt_pkg::OP_CLEAR, '1, '1, 1'b1, '1);
    send_request(OP_UNUSED_LAST, '1, '1, 1'b1, '1);
  endtask

  // fill to capacity, overflow, update in place, erase with full shift
  task automatic test_fill_and_overflow();
    logic [okvt_pkg::KEY_W-1:0] key;
    logic [okvt_pkg::VAL_W-1:0] val;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) key = '0;
      else if (i == TABLE_DEPTH - 1) key = '1;
      else key = {4'(i), 28'($urandom())};
      if (i == 0) val = '1;
      else if (i == TABLE_DEPTH - 1) val = '0;
      else val = $urandom();
      send_request(okvt_pkg::OP_REGISTER, key, val, 1'($urandom_range(0, 1)), 4'(i));
    end
    send_request(okvt_pkg::OP_REGISTER, 32'h5A5A_0000, 32'h0000_0001, 1'b0, '0);
    send_request(okvt_pkg::OP_REGISTER, '0, 32'h0000_0001, 1'b0, '0);
    send_request(okvt_pkg::OP_REGISTER, '0, 32'hA5A5_A5A5, 1'b1, '0);
    send_request(okvt_pkg::OP_READ, '0, '0, 1'b0, 4'(TABLE_DEPTH - 1));
    send_request(okvt_pkg::OP_ERASE, '0, '0, 1'b0, '0);
    send_request(okvt_pkg::OP_READ, '0, '0, 1'b0, 4'(TABLE_DEPTH - 1));
    send_request(okvt_pkg::OP_LOOKUP, '1, '0, 1'b0, '0);
    send_request(okvt_pkg::OP_CLEAR, '0, '0, 1'b0, '0);
  endtask

  // mixed keyed traffic with idle gaps on both sides
  task automatic test_keyed_traffic();
    run_traffic(400, 20, 35, 25, 15, 15, 2, 3);
  endtask

  // same mix, both sides streaming without gaps
  task automatic test_back_to_back();
    no_idle = 1'b1;
    run_traffic(100, 20, 35, 25, 15, 15, 2, 3);
    no_idle = 1'b0;
  endtask

  // keep the table near full so overflow and long shifts are common
  task automatic test_near_capacity();
    run_traffic(280, 19, 45, 20, 20, 15, 0, 0);
  endtask

  // all operation codes with loosely chosen keys
  task automatic test_noise();
    run_traffic(170, 24, 20, 15, 15, 15, 10, 25);
  endtask

  // main sequence
  initial begin
    int noop_total;
    in_valid_i = 1'b0;
    operation_i = '0;
    key_i = '0;
    value_i = '0;
    update_existing_i = 1'b0;
    index_i = '0;
    rst_ni = 1'b0;
    no_idle = 1'b0;
    table_fill = 0;
    mismatch_count = 0;
    results_checked = 0;
    full_seen = 0;
    peak_fill = 0;
    noop_total = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_fill_and_overflow();
    test_keyed_traffic();
    test_back_to_back();
    test_near_capacity();
    test_noise();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++) noop_total += op_tally[c];
    $display("requests: lookup %0d, register %0d, erase %0d, clear %0d, read %0d, no-op %0d",
             op_tally[okvt_pkg::OP_LOOKUP], op_tally[okvt_pkg::OP_REGISTER],
             op_tally[okvt_pkg::OP_ERASE], op_tally[okvt_pkg::OP_CLEAR],
             op_tally[okvt_pkg::OP_READ], noop_total);
    $display("results checked %0d, full rejections %0d, peak fill %0d, mismatches %0d",
             results_checked, full_seen, peak_fill, mismatch_count);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
